// ===== rtl/combined_tausworthe_generator_macros.svh =====
// Assertion macros for the combined Tausworthe generator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef COMBINED_TAUSWORTHE_GENERATOR_MACROS_SVH
`define COMBINED_TAUSWORTHE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, disabled during reset.
`define CTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/ctg_pkg.sv =====
// Shared types and constants for the combined Tausworthe generator.
// No dependencies.
package ctg_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BOUND_W = 31;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W = 5;

  localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;

  localparam logic [WORD_W-1:0] MASK_A = 32'hFFFF_FFFE;
  localparam logic [WORD_W-1:0] MASK_B = 32'hFFFF_FFF8;
  localparam logic [WORD_W-1:0] MASK_C = 32'hFFFF_FFF0;
  localparam logic [WORD_W-1:0] MASK_D = 32'hFFFF_FF80;

  typedef struct packed {
    logic [BOUND_W-1:0] bound;
    logic [WORD_W-1:0]  raw;
  } ctg_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/ctg_front.sv =====
// Front end: accepts requests, steps the four Tausworthe words, queues results.
// Depends on ctg_pkg.
module ctg_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ctg_pkg::WORD_W-1:0]  s_tdata,   // [30:0] bound, [31] zero
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ctg_pkg::WORD_W-1:0]  cfg_data,
  input  logic                        q_full,
  output logic                        q_push,
  output ctg_pkg::ctg_item_t          q_item
);

  logic [ctg_pkg::WORD_W-1:0] word_a, word_b, word_c, word_d;
  logic [ctg_pkg::WORD_W-1:0] word_a_next, word_b_next, word_c_next, word_d_next;
  logic [ctg_pkg::WORD_W-1:0] fb_a, fb_b, fb_c, fb_d;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign q_push    = s_tvalid && s_tready;

  always_comb begin
    fb_a = ((word_a << 6) ^ word_a) >> 13;
    fb_b = ((word_b << 2) ^ word_b) >> 27;
    fb_c = ((word_c << 13) ^ word_c) >> 21;
    fb_d = ((word_d << 3) ^ word_d) >> 12;
    word_a_next = ((word_a & ctg_pkg::MASK_A) << 18) ^ fb_a;
    word_b_next = ((word_b & ctg_pkg::MASK_B) << 2) ^ fb_b;
    word_c_next = ((word_c & ctg_pkg::MASK_C) << 7) ^ fb_c;
    word_d_next = ((word_d & ctg_pkg::MASK_D) << 13) ^ fb_d;
    q_item.raw   = word_a_next ^ word_b_next ^ word_c_next ^ word_d_next;
    q_item.bound = s_tdata[ctg_pkg::BOUND_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_a <= ctg_pkg::SEED_RESET;
      word_b <= ctg_pkg::SEED_RESET << 10;
      word_c <= ctg_pkg::SEED_RESET << 20;
      word_d <= ctg_pkg::SEED_RESET << 30;
    end else if (cfg_valid && cfg_ready) begin
      word_a <= cfg_data;
      word_b <= cfg_data << 10;
      word_c <= cfg_data << 20;
      word_d <= cfg_data << 30;
    end else if (q_push) begin
      word_a <= word_a_next;
      word_b <= word_b_next;
      word_c <= word_c_next;
      word_d <= word_d_next;
    end
  end

endmodule

// ===== rtl/ctg_queue.sv =====
// Small FIFO between front end and remainder unit.
// Depends on ctg_pkg.
module ctg_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ctg_pkg::ctg_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output ctg_pkg::ctg_item_t pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ctg_pkg::ctg_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ctg_back.sv =====
// Back end: bit-serial remainder unit and output register.
// Depends on ctg_pkg and combined_tausworthe_generator_macros.svh.
`include "combined_tausworthe_generator_macros.svh"

module ctg_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  ctg_pkg::ctg_item_t          q_item,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ctg_pkg::WORD_W-1:0]  m_tdata    // [31:0] value
);

  ctg_pkg::back_state_t state, state_next;

  logic [ctg_pkg::WORD_W-1:0]  dvd;
  logic [ctg_pkg::BOUND_W-1:0] rem, rem_next;
  logic [ctg_pkg::BOUND_W-1:0] bound;
  logic                        zero_bound;
  logic [ctg_pkg::CNT_W-1:0]   cnt;
  logic [ctg_pkg::WORD_W-1:0]  shifted;
  logic [ctg_pkg::WORD_W:0]    diff;
  logic                        out_free;
  logic                        last_step;

  assign out_free  = !m_tvalid || m_tready;
  assign last_step = (cnt == ctg_pkg::CNT_W'(ctg_pkg::DIV_STEPS - 1));

  always_comb begin
    shifted  = {rem, dvd[ctg_pkg::WORD_W-1]};
    diff     = {1'b0, shifted} - {2'b00, bound};
    rem_next = diff[ctg_pkg::WORD_W] ? shifted[ctg_pkg::BOUND_W-1:0]
                                     : diff[ctg_pkg::BOUND_W-1:0];
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ctg_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = (q_item.bound == '0) ? ctg_pkg::B_DONE : ctg_pkg::B_RUN;
        end
      end
      ctg_pkg::B_RUN: begin
        if (last_step) state_next = ctg_pkg::B_DONE;
      end
      ctg_pkg::B_DONE: begin
        if (out_free) state_next = ctg_pkg::B_IDLE;
      end
      default: state_next = ctg_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ctg_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ctg_pkg::B_IDLE && q_valid) begin
      dvd        <= q_item.raw;
      bound      <= q_item.bound;
      zero_bound <= (q_item.bound == '0);
      rem        <= '0;
      cnt        <= '0;
    end else if (state == ctg_pkg::B_RUN) begin
      dvd <= {dvd[ctg_pkg::WORD_W-2:0], 1'b0};
      rem <= rem_next;
      cnt <= cnt + ctg_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ctg_pkg::B_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ctg_pkg::B_DONE && out_free) begin
      m_tdata <= zero_bound ? dvd : {1'b0, rem};
    end
  end

  `CTG_ASSERT_SAME(a_rem_below_bound, clk, rst, state == ctg_pkg::B_RUN, rem < bound)
  `CTG_ASSERT_SAME(a_run_nonzero, clk, rst, state == ctg_pkg::B_RUN, !zero_bound)
  `CTG_ASSERT_NEXT(a_run_length, clk, rst, state == ctg_pkg::B_RUN && !last_step, state == ctg_pkg::B_RUN)
  `CTG_ASSERT_SAME(a_out_from_done, clk, rst, $rose(m_tvalid), $past(state) == ctg_pkg::B_DONE)

endmodule

// ===== rtl/combined_tausworthe_generator.sv =====
// A request with a nonzero bound passes the queue, the 32-step bit-serial remainder
// unit and the output register; a request with bound 0 skips the remainder steps.
// The remainder unit serves one request at a time, popping the next after hand-off.
// Up to QUEUE_DEPTH requests are taken ahead while the remainder unit is busy.
// Reset (rst, synchronous): words reload from seed 1, queue and output empty.
module combined_tausworthe_generator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [30:0] bound, [31] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // [31:0] seed
);

  logic               q_full, q_push, q_valid, q_pop;
  ctg_pkg::ctg_item_t push_item, pop_item;

  ctg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  ctg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (pop_item)
  );

  ctg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== test/tb_combined_tausworthe_generator.sv =====
// Testbench for combined_tausworthe_generator: seeds, bounded requests and stalls on both streams.
// Checks every output value against a built-in model of the four LFSR113 words.
// Depends on ctg_pkg and the combined_tausworthe_generator RTL.
module tb_combined_tausworthe_generator;

  class tausworthe_scoreboard;
    logic [31:0] word_a, word_b, word_c, word_d;
    logic [31:0] expected_values[$];
    int unsigned mismatches;

    function void load_seed(input logic [31:0] seed);
      word_a = seed;
      word_b = seed << 10;
      word_c = seed << 20;
      word_d = seed << 30;
    endfunction

    function logic [31:0] next_output();
      logic [31:0] fb;
      fb = ((word_a << 6) ^ word_a) >> 13;
      word_a = ((word_a & ctg_pkg::MASK_A) << 18) ^ fb;
      fb = ((word_b << 2) ^ word_b) >> 27;
      word_b = ((word_b & ctg_pkg::MASK_B) << 2) ^ fb;
      fb = ((word_c << 13) ^ word_c) >> 21;
      word_c = ((word_c & ctg_pkg::MASK_C) << 7) ^ fb;
      fb = ((word_d << 3) ^ word_d) >> 12;
      word_d = ((word_d & ctg_pkg::MASK_D) << 13) ^ fb;
      return word_a ^ word_b ^ word_c ^ word_d;
    endfunction

    function void note_request(input logic [30:0] bound);
      logic [31:0] raw;
      raw = next_output();
      if (bound == '0) begin
        expected_values.push_back(raw);
      end else begin
        expected_values.push_back(raw % {1'b0, bound});
      end
    endfunction

    function void check_value(input logic [31:0] actual);
      logic [31:0] wanted;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected value transfer, actual %h", $time, actual);
        mismatches++;
      end else begin
        wanted = expected_values.pop_front();
        if (actual !== wanted) begin
          $display("%0t: value mismatch, expected %h actual %h", $time, wanted, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_values.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [30:0] bound, [31] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] value
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;  // [31:0] seed
  logic [9:0]  ready_cycle = '0;

  tausworthe_scoreboard board;

  combined_tausworthe_generator dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // receiver: full rate, random stalls, one-in-eight, coin flip
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 10'd1;
    case (ready_cycle[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (ready_cycle[2:0] == 3'd0);
      default: m_tready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_value(m_tdata);
    end
  end

  task automatic send_request(input logic [30:0] bound);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, bound};
    do @(posedge clk); while (!s_tready);
    board.note_request(bound);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    while (board.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= seed;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.load_seed(seed);
  endtask

  function automatic logic [30:0] random_bound();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 31'($urandom_range(1, 255));
      2: return 31'($urandom);
      default: return 31'($urandom >> $urandom_range(1, 31));
    endcase
  endfunction

  // bursts of random length, with random gaps unless no_gaps is set; valid stays high across a burst
  task automatic send_random(input int unsigned count, input bit no_gaps);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int unsigned i = 0; i < burst && sent < count; i++) begin
        send_request(random_bound());
        sent++;
      end
      if (!no_gaps && $urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    logic [30:0] edge_bounds[12];
    logic [31:0] seeds[6];

    board = new();
    board.load_seed(ctg_pkg::SEED_RESET);
    edge_bounds = '{31'd0, 31'd1, 31'd2, 31'd3, 31'h7FFF_FFFF, 31'h4000_0000,
                    31'h5555_5555, 31'h2AAA_AAAA, 31'd0, 31'd7, 31'd1000, 31'h7FFF_FFFE};
    seeds = '{32'h8000_0000, 32'd1, 32'hDEAD_BEEF, 32'($urandom), 32'($urandom),
              32'($urandom)};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset seed first, then all-ones and the all-zero trap
    foreach (edge_bounds[i]) send_request(edge_bounds[i]);
    s_tvalid <= 1'b0;
    write_seed(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_request(edge_bounds[i]);
    s_tvalid <= 1'b0;
    write_seed(32'd0);
    for (int i = 0; i < 5; i++) send_request(edge_bounds[i]);
    s_tvalid <= 1'b0;
    send_random(40, 1'b0);

    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_random(125, i == 2);
    end

    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb_combined_tausworthe_generator: clean");
    end else begin
      $display("tb_combined_tausworthe_generator: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_combined_tausworthe_generator: errors");
    $finish;
  end

endmodule
